// ===== rtl/lsrg_pkg.sv =====
// Shared types, constants and neighbor table of the Laplacian row generator.
`default_nettype none
package lsrg_pkg;

	localparam int MAX_DIM    = 1024;
	localparam int CFG_W      = 11;
	localparam int STENCIL_W  = 5;
	localparam int IDX_W      = 30;
	localparam int CO_W       = $clog2(MAX_DIM);
	localparam int PLANE_W    = 2 * CO_W + 1;
	localparam int N_W        = 3 * CO_W + 1;
	localparam int COL_W      = IDX_W + 2;
	localparam int VAL_W      = 6;
	localparam int NBR        = 26;
	localparam int NBR_FACE   = 6;
	localparam int SEL_W      = $clog2(NBR);
	localparam int CNT_W      = $clog2(CO_W);
	localparam int REG_IDX_W  = 2;
	localparam int SETTLE_W   = 2;
	localparam int SETTLE     = 3;
	localparam int QAW        = 1;
	localparam int QDEPTH     = 1 << QAW;

	localparam logic [STENCIL_W-1:0] REQ_3D_SMALL = STENCIL_W'(7);
	localparam logic [STENCIL_W-1:0] REQ_2D_SMALL = STENCIL_W'(5);

	localparam logic signed [VAL_W-1:0] VAL_NBR     = -6'sd1;
	localparam logic signed [VAL_W-1:0] VAL_DIAG_27 = 6'sd26;
	localparam logic signed [VAL_W-1:0] VAL_DIAG_7  = 6'sd6;
	localparam logic signed [VAL_W-1:0] VAL_DIAG_9  = 6'sd8;
	localparam logic signed [VAL_W-1:0] VAL_DIAG_5  = 6'sd4;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GRID_X  = 2'd0,
		REG_GRID_Y  = 2'd1,
		REG_GRID_Z  = 2'd2,
		REG_STENCIL = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STEP_ZERO = 2'b00,
		STEP_NEG  = 2'b01,
		STEP_POS  = 2'b10
	} step_t;

	typedef struct packed {
		step_t dx;
		step_t dy;
		step_t dz;
	} nbr_off_t;

	// Settled grid geometry seen by both halves.
	typedef struct packed {
		logic [CFG_W-1:0]        nx;
		logic [PLANE_W-1:0]      plane;
		logic [N_W-1:0]          n;
		logic [CO_W-1:0]         nx_m1;
		logic [CO_W-1:0]         ny_m1;
		logic [CO_W-1:0]         nz_m1;
		logic                    big;
		logic signed [VAL_W-1:0] diag;
		logic                    settled;
	} lsrg_cfg_t;

	// One classified row on its way from the front to the back.
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [CO_W-1:0]  ix;
		logic [CO_W-1:0]  iy;
		logic [CO_W-1:0]  iz;
		logic             bad;
	} lsrg_item_t;

	// Faces first, then edges and corners, in the fixed emission order.
	function automatic nbr_off_t nbr_off(input logic [SEL_W-1:0] k);
		nbr_off_t o;
		o = '{STEP_ZERO, STEP_ZERO, STEP_ZERO};
		case (k)
			5'd0:  o = '{STEP_ZERO, STEP_ZERO, STEP_NEG};
			5'd1:  o = '{STEP_ZERO, STEP_ZERO, STEP_POS};
			5'd2:  o = '{STEP_ZERO, STEP_NEG,  STEP_ZERO};
			5'd3:  o = '{STEP_ZERO, STEP_POS,  STEP_ZERO};
			5'd4:  o = '{STEP_NEG,  STEP_ZERO, STEP_ZERO};
			5'd5:  o = '{STEP_POS,  STEP_ZERO, STEP_ZERO};
			5'd6:  o = '{STEP_NEG,  STEP_NEG,  STEP_NEG};
			5'd7:  o = '{STEP_ZERO, STEP_NEG,  STEP_NEG};
			5'd8:  o = '{STEP_POS,  STEP_NEG,  STEP_NEG};
			5'd9:  o = '{STEP_NEG,  STEP_ZERO, STEP_NEG};
			5'd10: o = '{STEP_POS,  STEP_ZERO, STEP_NEG};
			5'd11: o = '{STEP_NEG,  STEP_POS,  STEP_NEG};
			5'd12: o = '{STEP_ZERO, STEP_POS,  STEP_NEG};
			5'd13: o = '{STEP_POS,  STEP_POS,  STEP_NEG};
			5'd14: o = '{STEP_NEG,  STEP_NEG,  STEP_ZERO};
			5'd15: o = '{STEP_POS,  STEP_NEG,  STEP_ZERO};
			5'd16: o = '{STEP_NEG,  STEP_POS,  STEP_ZERO};
			5'd17: o = '{STEP_POS,  STEP_POS,  STEP_ZERO};
			5'd18: o = '{STEP_NEG,  STEP_NEG,  STEP_POS};
			5'd19: o = '{STEP_ZERO, STEP_NEG,  STEP_POS};
			5'd20: o = '{STEP_POS,  STEP_NEG,  STEP_POS};
			5'd21: o = '{STEP_NEG,  STEP_ZERO, STEP_POS};
			5'd22: o = '{STEP_POS,  STEP_ZERO, STEP_POS};
			5'd23: o = '{STEP_NEG,  STEP_POS,  STEP_POS};
			5'd24: o = '{STEP_ZERO, STEP_POS,  STEP_POS};
			5'd25: o = '{STEP_POS,  STEP_POS,  STEP_POS};
			default: o = '{STEP_ZERO, STEP_ZERO, STEP_ZERO};
		endcase
		return o;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/laplacian_stencil_row_generator.sv =====
// Top level of the grid Laplacian row generator.
// Each input beat carries a linear grid index; the block answers with that row's nonzero
// entries, off-diagonal neighbors first (value -1) and the diagonal last with last_entry
// set, or with a single bad_row beat when the index lies outside the grid. The front end
// loads the row, then runs two 10-bit restoring divisions at one quotient bit per cycle
// and hands the result into a two-entry queue; a row outside the grid skips the
// divisions. The back end sends one entry per cycle while out_ready is high: up to 5, 9,
// 7 or 27 entries per row, fewer at grid boundaries. A fresh input beat is taken while
// the previous rows are still being divided or emitted. After a register write, in_ready
// stays low while the grid products settle.
`default_nettype none
module laplacian_stencil_row_generator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lsrg_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire logic [lsrg_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [lsrg_pkg::IDX_W-1:0]        row_index,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [lsrg_pkg::IDX_W-1:0]             row_number,
	output logic [lsrg_pkg::IDX_W-1:0]             column_number,
	output logic signed [lsrg_pkg::VAL_W-1:0]      entry_value,
	output logic                                   last_entry,
	output logic                                   bad_row
);
	import lsrg_pkg::*;

	lsrg_cfg_t  cfg;
	logic       push_valid, push_ready;
	lsrg_item_t push_item;
	logic       pop_valid, pop_ready;
	lsrg_item_t pop_item;

	lsrg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lsrg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.row_index  (row_index),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	lsrg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	lsrg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head_valid    (pop_valid),
		.head_ready    (pop_ready),
		.head_item     (pop_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.row_number    (row_number),
		.column_number (column_number),
		.entry_value   (entry_value),
		.last_entry    (last_entry),
		.bad_row       (bad_row)
	);

endmodule
`default_nettype wire

// ===== rtl/lsrg_cfg.sv =====
// Configuration registers and the derived grid geometry.
`default_nettype none
module lsrg_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [lsrg_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [lsrg_pkg::CFG_W-1:0]       cfg_data,
	output lsrg_pkg::lsrg_cfg_t                   cfg
);
	import lsrg_pkg::*;

	logic [CFG_W-1:0]     gx_q, gy_q, gz_q;
	logic [STENCIL_W-1:0] sreq_q;
	logic [SETTLE_W-1:0]  settle_q;
	logic [PLANE_W-1:0]   plane_q;
	logic [N_W-1:0]       n_q;
	logic [CFG_W-1:0]     nx_c, ny_c, nz_c;
	logic                 is3d;
	logic                 wr;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		return (v > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : v;
	endfunction

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	always_comb begin
		nx_c = clamp_dim(gx_q);
		ny_c = clamp_dim(gy_q);
		nz_c = clamp_dim(gz_q);
		is3d = nz_c > CFG_W'(1);

		cfg.nx      = nx_c;
		cfg.plane   = plane_q;
		cfg.n       = n_q;
		cfg.nx_m1   = CO_W'(nx_c - CFG_W'(1));
		cfg.ny_m1   = CO_W'(ny_c - CFG_W'(1));
		cfg.nz_m1   = CO_W'(nz_c - CFG_W'(1));
		cfg.big     = is3d ? (sreq_q > REQ_3D_SMALL) : (sreq_q > REQ_2D_SMALL);
		if (is3d) begin
			cfg.diag = cfg.big ? VAL_DIAG_27 : VAL_DIAG_7;
		end else begin
			cfg.diag = cfg.big ? VAL_DIAG_9 : VAL_DIAG_5;
		end
		cfg.settled = (settle_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q     <= CFG_W'(1);
			gy_q     <= CFG_W'(1);
			gz_q     <= CFG_W'(1);
			sreq_q   <= STENCIL_W'(5);
			settle_q <= SETTLE_W'(SETTLE);
		end else begin
			if (wr) begin
				case (cfg_reg_t'(cfg_index))
					REG_GRID_X:  gx_q   <= cfg_data;
					REG_GRID_Y:  gy_q   <= cfg_data;
					REG_GRID_Z:  gz_q   <= cfg_data;
					REG_STENCIL: sreq_q <= cfg_data[STENCIL_W-1:0];
					default:     ;
				endcase
			end
			// hold intake until both products reflect the new sizes
			if (wr) begin
				settle_q <= SETTLE_W'(SETTLE);
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		plane_q <= PLANE_W'(nx_c) * PLANE_W'(ny_c);
		n_q     <= N_W'(plane_q) * N_W'(nz_c);
	end

endmodule
`default_nettype wire

// ===== rtl/lsrg_front.sv =====
// Front end: accepts a row index, range-checks it and splits it into grid coordinates.
`default_nettype none
module lsrg_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lsrg_pkg::lsrg_cfg_t          cfg,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [lsrg_pkg::IDX_W-1:0]   row_index,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output lsrg_pkg::lsrg_item_t              push_item
);
	import lsrg_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_DIVZ = 4'b0010,
		F_DIVY = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t            state_q;
	logic               hold_valid_q;
	logic [IDX_W-1:0]   hold_row_q;
	logic [IDX_W-1:0]   row_q;
	logic [IDX_W-1:0]   r_q;
	logic [CO_W-1:0]    q_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CO_W-1:0]    ix_q, iy_q, iz_q;
	logic               bad_q;

	logic               take;
	logic               row_bad;
	logic [PLANE_W-1:0] div_d;
	logic [N_W-1:0]     shifted;
	logic [N_W-1:0]     trial;
	logic               ge;
	logic [IDX_W-1:0]   r_nx;
	logic [CO_W-1:0]    q_nx;

	assign in_ready = !hold_valid_q && cfg.settled;
	assign take     = (state_q == F_IDLE) && hold_valid_q;

	// one quotient bit per cycle; both quotients stay below MAX_DIM
	always_comb begin
		row_bad = {1'b0, hold_row_q} >= cfg.n;
		div_d   = (state_q == F_DIVZ) ? cfg.plane : PLANE_W'(cfg.nx);
		shifted = N_W'(div_d) << cnt_q;
		trial   = {1'b0, r_q} - shifted;
		ge      = !trial[N_W-1];
		r_nx    = ge ? trial[IDX_W-1:0] : r_q;
		q_nx    = q_q;
		q_nx[cnt_q] = ge;
	end

	assign push_valid = (state_q == F_PUSH);
	assign push_item  = '{row: row_q, ix: ix_q, iy: iy_q, iz: iz_q, bad: bad_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			hold_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (in_valid && in_ready) begin
				hold_valid_q <= 1'b1;
			end else if (take) begin
				hold_valid_q <= 1'b0;
			end
			case (state_q)
				F_IDLE: begin
					if (hold_valid_q) begin
						cnt_q   <= CNT_W'(CO_W - 1);
						state_q <= row_bad ? F_PUSH : F_DIVZ;
					end
				end
				F_DIVZ: begin
					if (cnt_q == '0) begin
						cnt_q   <= CNT_W'(CO_W - 1);
						state_q <= F_DIVY;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				F_DIVY: begin
					if (cnt_q == '0) begin
						state_q <= F_PUSH;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_row_q <= row_index;
		end
		case (state_q)
			F_IDLE: begin
				row_q <= hold_row_q;
				r_q   <= hold_row_q;
				q_q   <= '0;
				bad_q <= row_bad;
			end
			F_DIVZ: begin
				r_q <= r_nx;
				if (cnt_q == '0) begin
					iz_q <= q_nx;
					q_q  <= '0;
				end else begin
					q_q <= q_nx;
				end
			end
			F_DIVY: begin
				r_q <= r_nx;
				q_q <= q_nx;
				if (cnt_q == '0) begin
					iy_q <= q_nx;
					ix_q <= r_nx[CO_W-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/lsrg_queue.sv =====
// Short queue of classified rows between the front and the back.
`default_nettype none
module lsrg_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push_valid,
	output logic                       push_ready,
	input  wire lsrg_pkg::lsrg_item_t  push_item,
	output logic                       pop_valid,
	input  wire logic                  pop_ready,
	output lsrg_pkg::lsrg_item_t       pop_item
);
	import lsrg_pkg::*;

	lsrg_item_t       mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     cnt_q;
	logic             push, pop;

	assign push_ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QAW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lsrg_back.sv =====
// Back end: walks the in-grid neighbors of a row and emits one matrix entry per beat.
`default_nettype none
module lsrg_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lsrg_pkg::lsrg_cfg_t               cfg,
	input  wire logic                              head_valid,
	output logic                                   head_ready,
	input  wire lsrg_pkg::lsrg_item_t              head_item,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [lsrg_pkg::IDX_W-1:0]             row_number,
	output logic [lsrg_pkg::IDX_W-1:0]             column_number,
	output logic signed [lsrg_pkg::VAL_W-1:0]      entry_value,
	output logic                                   last_entry,
	output logic                                   bad_row
);
	import lsrg_pkg::*;

	lsrg_item_t              cur_q;
	logic [NBR-1:0]          mask_q;
	logic                    busy_q;
	logic                    out_valid_q;
	logic [IDX_W-1:0]        row_q;
	logic [IDX_W-1:0]        col_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    last_q;
	logic                    bad_q;

	logic [NBR-1:0]          mask_new;
	logic [SEL_W-1:0]        sel;
	nbr_off_t                off_sel;
	logic signed [COL_W-1:0] col_w;
	logic                    fin;
	logic                    adv;
	logic                    fire;
	logic                    load;
	logic [IDX_W-1:0]        col_e;
	logic signed [VAL_W-1:0] val_e;
	logic                    last_e;

	function automatic logic step_ok(input step_t s, input logic [CO_W-1:0] c,
			input logic [CO_W-1:0] m1);
		logic ok;
		case (s)
			STEP_NEG: ok = (c != '0);
			STEP_POS: ok = (c != m1);
			default:  ok = 1'b1;
		endcase
		return ok;
	endfunction

	function automatic logic signed [COL_W-1:0] step_term(input step_t s,
			input logic [PLANE_W-1:0] mag);
		logic signed [COL_W-1:0] m;
		logic signed [COL_W-1:0] t;
		m = $signed(COL_W'(mag));
		case (s)
			STEP_NEG: t = -m;
			STEP_POS: t = m;
			default:  t = '0;
		endcase
		return t;
	endfunction

	// neighbor mask of the incoming row; edge and corner entries only for 9 and 27 points
	always_comb begin
		nbr_off_t off;
		for (int k = 0; k < NBR; k++) begin
			off = nbr_off(SEL_W'(k));
			mask_new[k] = step_ok(off.dx, head_item.ix, cfg.nx_m1)
				&& step_ok(off.dy, head_item.iy, cfg.ny_m1)
				&& step_ok(off.dz, head_item.iz, cfg.nz_m1)
				&& (k < NBR_FACE || cfg.big);
		end
	end

	// lowest pending neighbor goes next
	always_comb begin
		sel = '0;
		for (int k = NBR - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				sel = SEL_W'(k);
			end
		end
		off_sel = nbr_off(sel);
		col_w   = $signed(COL_W'(cur_q.row))
			+ step_term(off_sel.dx, PLANE_W'(1))
			+ step_term(off_sel.dy, PLANE_W'(cfg.nx))
			+ step_term(off_sel.dz, cfg.plane);
	end

	always_comb begin
		fin  = cur_q.bad || (mask_q == '0);
		adv  = !out_valid_q || out_ready;
		fire = busy_q && adv;
		load = head_valid && (!busy_q || (fire && fin));
		if (cur_q.bad) begin
			col_e  = '0;
			val_e  = '0;
			last_e = 1'b0;
		end else if (mask_q == '0) begin
			col_e  = cur_q.row;
			val_e  = cfg.diag;
			last_e = 1'b1;
		end else begin
			col_e  = col_w[IDX_W-1:0];
			val_e  = VAL_NBR;
			last_e = 1'b0;
		end
	end

	assign head_ready    = load;
	assign out_valid     = out_valid_q;
	assign row_number    = row_q;
	assign column_number = col_q;
	assign entry_value   = val_q;
	assign last_entry    = last_q;
	assign bad_row       = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (load) begin
				busy_q <= 1'b1;
			end else if (fire && fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			row_q  <= cur_q.row;
			col_q  <= col_e;
			val_q  <= val_e;
			last_q <= last_e;
			bad_q  <= cur_q.bad;
			// drop the neighbor just sent
			if (!fin) begin
				mask_q[sel] <= 1'b0;
			end
		end
		if (load) begin
			cur_q  <= head_item;
			mask_q <= mask_new;
		end
	end

endmodule
`default_nettype wire
